// ===== rtl/rtu_frame_receiver_core_defines.svh =====
// Assertion macros for the frame receiver RTL.
`ifndef RTU_FRAME_RECEIVER_CORE_DEFINES_SVH
`define RTU_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition holds in the same cycle as the trigger.
`define RTU_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("rtu frame receiver: same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define RTU_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("rtu frame receiver: next-cycle check failed");

`else

`define RTU_ASSERT_NOW(label, clk, rst_n, trig, cond)
`define RTU_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ===== rtl/rtu_rx_pkg.sv =====
// Types, constants and the CRC-16 byte update for the frame receiver.
`timescale 1ns / 1ps

package rtu_rx_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_BYTE  = 2'd1;
    localparam t_mode MODE_ERROR = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

    localparam int MAX_FRAME_DEF = 256;
    localparam int MIN_FRAME_DEF = 4;

    localparam logic [15:0] GUARD_RESET = 16'd4;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] SIL_MAX     = 16'hFFFF;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/rtu_frame_receiver_core.sv =====
// Serial-slave frame receiver: byte/tick intake, silence guard and CRC-16 check.
`timescale 1ns / 1ps
`include "rtu_frame_receiver_core_defines.svh"

// Usage
//   Input channel (i_in_valid / o_in_ready): one beat is a time tick, a received
//   byte, a line error or nothing, selected by i_mode. A line error restarts reception.
//   Output channel (o_out_valid / i_out_ready): one beat per closed frame with
//   the pass flag, the frame length (CRC included) and the received trailer.
//   Config channel (i_cfg_valid / o_cfg_ready): writes guard_ticks, the number
//   of silent ticks after the last byte that closes a frame. Always ready.
// Timing
//   A beat is taken into an input register, then handled from there against
//   the frame state; a result beat passes through the output register. One
//   beat per cycle is sustained unless a closing beat waits on a stalled output;
//   the CRC byte update and silence compare are done in the state update.
// Reset and stall
//   Reset clears the frame state, empties both registers and sets guard_ticks
//   to 4. While a result waits on a stalled output, bytes and ticks that close
//   no frame still pass; a beat that would close another frame holds in the
//   input register and blocks further input until the output drains.
module rtu_frame_receiver_core #(
    parameter int MAX_FRAME = rtu_rx_pkg::MAX_FRAME_DEF,
    parameter int MIN_FRAME = rtu_rx_pkg::MIN_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rtu_rx_pkg::t_mode   i_mode,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_frame_ok,
    output logic [8:0]          o_frame_length,
    output logic [15:0]         o_received_crc,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import rtu_rx_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    // input register
    logic        r_s1_valid;
    t_mode       r_mode;
    logic [7:0]  r_byte;

    // frame state
    logic          r_receiving, n_receiving;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [15:0]   r_silence, n_silence;
    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_held, n_held;
    logic [15:0]   r_guard;

    // output register
    logic        r_out_valid;
    logic        r_frame_ok;
    logic [8:0]  r_frame_length;
    logic [15:0] r_received_crc;

    logic        w_result;
    logic        w_out_free;
    logic        w_go;
    logic [15:0] w_sil_inc;
    logic [15:0] w_trailer;
    logic        w_ok;
    logic [8:0]  w_length;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_go       = r_s1_valid && (!w_result || w_out_free);
    assign o_in_ready = !r_s1_valid || w_go;
    assign o_cfg_ready = 1'b1;

    assign w_sil_inc = (r_silence == SIL_MAX) ? r_silence : r_silence + 16'd1;
    assign w_trailer = (r_byte_count >= CW'(2)) ? {r_held[7:0], r_held[15:8]} : 16'h0000;
    assign w_ok      = (r_byte_count >= CW'(MIN_FRAME)) && (r_byte_count >= CW'(2)) &&
                       (r_crc == w_trailer);
    assign w_length  = 9'(r_byte_count);

    always_comb begin
        n_receiving  = r_receiving;
        n_byte_count = r_byte_count;
        n_silence    = r_silence;
        n_crc        = r_crc;
        n_held       = r_held;
        w_result     = 1'b0;
        unique case (r_mode)
            MODE_ERROR: begin
                n_receiving  = 1'b0;
                n_byte_count = '0;
                n_silence    = '0;
                n_crc        = CRC_INIT;
                n_held       = '0;
            end
            MODE_BYTE: begin
                n_receiving = 1'b1;
                n_silence   = '0;
                // drop bytes past the frame limit, but they still reset silence
                if (r_byte_count < CW'(MAX_FRAME)) begin
                    if (r_byte_count >= CW'(2)) begin
                        n_crc = crc16_feed(r_crc, r_held[15:8]);
                    end
                    n_held       = {r_held[7:0], r_byte};
                    n_byte_count = r_byte_count + CW'(1);
                end
            end
            MODE_TICK: begin
                if (r_receiving) begin
                    n_silence = w_sil_inc;
                    if (w_sil_inc >= r_guard) begin
                        w_result     = r_s1_valid;
                        n_receiving  = 1'b0;
                        n_byte_count = '0;
                        n_silence    = '0;
                        n_crc        = CRC_INIT;
                        n_held       = '0;
                    end
                end
            end
            MODE_NONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_receiving  <= 1'b0;
            r_byte_count <= '0;
            r_silence    <= '0;
            r_crc        <= CRC_INIT;
            r_held       <= '0;
            r_guard      <= GUARD_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_guard <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_go) begin
                r_receiving  <= n_receiving;
                r_byte_count <= n_byte_count;
                r_silence    <= n_silence;
                r_crc        <= n_crc;
                r_held       <= n_held;
            end
            if (w_go && w_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
        if (w_go && w_result) begin
            r_frame_ok     <= w_ok;
            r_frame_length <= w_length;
            r_received_crc <= w_trailer;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_frame_length = r_frame_length;
    assign o_received_crc = r_received_crc;

    // no bytes are held while waiting for the first byte of a frame
    `RTU_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !r_receiving, r_byte_count == '0)
    // a closed frame leaves a result waiting and the receiver back at waiting
    `RTU_ASSERT_NEXT(a_close_restart, i_clk, i_rst_n, w_go && w_result,
                     o_out_valid && !r_receiving)
    // the byte count stops at the frame limit
    `RTU_ASSERT_NOW(a_count_limit, i_clk, i_rst_n, 1'b1, r_byte_count <= CW'(MAX_FRAME))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the serial-slave frame receiver with CRC-16 check.
`timescale 1ns / 1ps

module testbench;
    import rtu_rx_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic        ok;
        logic [8:0]  length;
        logic [15:0] trailer;
    } t_frame;

    // Bitwise CRC-16/MODBUS over one byte.
    function automatic logic [15:0] crc_next(logic [15:0] acc, logic [7:0] data);
        logic [15:0] r;
        logic        lsb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            lsb = r[0] ^ data[k];
            r = {1'b0, r[15:1]};
            if (lsb) begin
                r = r ^ 16'hA001;
            end
        end
        return r;
    endfunction

    class frame_scoreboard;
        logic [15:0] guard;
        bit          open;
        int          count;
        int          quiet;
        logic [15:0] crc_acc;
        logic [15:0] tail;
        t_frame      frames[$];
        int          errors;

        function new();
            guard = GUARD_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            open = 0;
            count = 0;
            quiet = 0;
            crc_acc = CRC_INIT;
            tail = 16'h0000;
        endfunction

        // Advance the frame state by one accepted input beat.
        function void note_beat(t_mode m, logic [7:0] b);
            t_frame f;
            case (m)
                MODE_ERROR: begin
                    restart();
                end
                MODE_BYTE: begin
                    open = 1;
                    quiet = 0;
                    if (count < MAX_FRAME_DEF) begin
                        if (count >= 2) begin
                            crc_acc = crc_next(crc_acc, tail[15:8]);
                        end
                        tail = {tail[7:0], b};
                        count++;
                    end
                end
                MODE_TICK: begin
                    if (open) begin
                        if (quiet < 32'hFFFF) begin
                            quiet++;
                        end
                        if (quiet >= int'(guard)) begin
                            f.trailer = (count >= 2) ? {tail[7:0], tail[15:8]} : 16'h0000;
                            f.ok = (count >= MIN_FRAME_DEF) && (crc_acc == f.trailer);
                            f.length = count[8:0];
                            frames.push_back(f);
                            restart();
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_frame(logic ok, logic [8:0] len, logic [15:0] trl);
            t_frame f;
            if (frames.size() == 0) begin
                $display("%0t: unexpected frame ok=%0d length=%0d crc=%h",
                         $time, ok, len, trl);
                errors++;
                return;
            end
            f = frames.pop_front();
            if (ok !== f.ok) begin
                $display("%0t: frame_ok expected %0d actual %0d", $time, f.ok, ok);
                errors++;
            end
            if (len !== f.length) begin
                $display("%0t: frame_length expected %0d actual %0d", $time, f.length, len);
                errors++;
            end
            if (trl !== f.trailer) begin
                $display("%0t: received_crc expected %h actual %h", $time, f.trailer, trl);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_mode       in_mode = MODE_TICK;
    logic [7:0]  in_byte = 8'h00;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = 16'h0000;
    logic        in_ready;
    logic        out_valid;
    logic        frame_ok;
    logic [8:0]  frame_length;
    logic [15:0] received_crc;
    logic        cfg_ready;

    frame_scoreboard sb = new();

    int burst_left = 0;
    int item_count = 0;
    int stall_style = 0;
    int stall_left = 0;

    rtu_frame_receiver_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (in_mode),
        .i_rx_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_ok     (frame_ok),
        .o_frame_length (frame_length),
        .o_received_crc (received_crc),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stall pattern: free-running, coin-flip, or long stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_style)
            0: out_ready = 1'b1;
            1: out_ready = $urandom_range(0, 1);
            default: out_ready = (stall_left == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            sb.check_frame(frame_ok, frame_length, received_crc);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(t_mode m, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
        end
        burst_left--;
        if (m != MODE_NONE && (m != MODE_TICK || sb.open)) begin
            item_count++;
        end
        in_valid = 1'b1;
        in_mode = m;
        in_byte = b;
        do @(posedge i_clk); while (!in_ready);
        sb.note_beat(m, b);
        @(negedge i_clk);
    endtask

    task automatic send_frame(int n, bit corrupt);
        logic [7:0]  data[$];
        logic [15:0] c;
        int          pos;
        int          cap;
        int          len;
        c = CRC_INIT;
        for (int k = 0; k < n; k++) begin
            data.push_back(8'($urandom_range(0, 255)));
        end
        // Bytes past the frame limit are dropped, so the trailer sits at the limit.
        len = (n > MAX_FRAME_DEF) ? MAX_FRAME_DEF : n;
        if (len >= 2) begin
            for (int k = 0; k < len - 2; k++) begin
                c = crc_next(c, data[k]);
            end
            data[len - 2] = c[7:0];
            data[len - 1] = c[15:8];
        end
        if (corrupt && n > 0) begin
            pos = $urandom_range(0, n - 1);
            data[pos] = data[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int k = 0; k < n; k++) begin
            // Insert silence shorter than the guard; the next byte clears it.
            if (k > 0 && sb.guard >= 2 && $urandom_range(0, 5) == 0) begin
                cap = (sb.guard > 10) ? 10 : int'(sb.guard) - 1;
                repeat ($urandom_range(1, cap)) send_beat(MODE_TICK, 8'($urandom_range(0, 255)));
            end
            send_beat(MODE_BYTE, data[k]);
        end
    endtask

    task automatic close_frame();
        while (sb.open) begin
            send_beat(MODE_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic finish_phase();
        if (sb.open) begin
            if (sb.guard <= 64) begin
                close_frame();
            end else begin
                send_beat(MODE_ERROR, 8'($urandom_range(0, 255)));
            end
        end
        drain_results();
    endtask

    task automatic write_guard(logic [15:0] g);
        cfg_valid = 1'b1;
        cfg_data = g;
        do @(posedge i_clk); while (!cfg_ready);
        sb.guard = g;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(int budget, bit pause_mid);
        int  start;
        int  pick;
        bit  paused;
        start = item_count;
        paused = 0;
        while (item_count - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame($urandom_range(4, 12), 0);
                close_frame();
            end else if (pick < 70) begin
                send_frame($urandom_range(4, 12), 1);
                close_frame();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end else if (pick < 90) begin
                // Break the frame off with a line error before it closes.
                send_frame($urandom_range(1, 10), 0);
                send_beat(MODE_ERROR, 8'($urandom_range(0, 255)));
            end else begin
                send_frame($urandom_range(1, 3), $urandom_range(0, 1));
                close_frame();
            end
            if (pause_mid && !paused && item_count - start >= budget / 2) begin
                drain_results();
                paused = 1;
            end
        end
        finish_phase();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset guard.
        send_beat(MODE_TICK, 8'hFF);
        send_beat(MODE_NONE, 8'hFF);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_ERROR, 8'hFF);
        send_beat(MODE_BYTE, 8'hFF);
        close_frame();
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_NONE, 8'h00);
        send_beat(MODE_BYTE, 8'hFF);
        close_frame();
        send_frame(3, 0);
        close_frame();
        send_frame(4, 0);
        close_frame();
        send_frame(4, 1);
        close_frame();
        finish_phase();

        write_guard(16'd0);
        send_frame(5, 0);
        close_frame();
        finish_phase();

        // Long guard: the silence sent here does not close the frame, a line error ends it.
        write_guard(16'hFFFF);
        send_frame(4, 0);
        repeat (20) send_beat(MODE_TICK, 8'h00);
        finish_phase();

        // Random part over several guard settings.
        write_guard(16'd1);
        random_phase(50, 0);
        write_guard(16'($urandom_range(2, 8)));
        random_phase(50, 1);
        write_guard(16'($urandom_range(2, 8)));
        send_frame(MAX_FRAME_DEF + 2, 0);
        close_frame();
        random_phase(50, 0);
        write_guard(GUARD_RESET);
        random_phase(50, 0);

        drain_results();
        if (sb.errors == 0 && sb.frames.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
